// ----- src/deq_pkg.sv -----
// Shared types and defaults for the double-ended queue.
package deq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int WIDTH_DEF = 32;

  // Fixed widths of the stream fields
  localparam int ACTION_W = 2;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 2;
  localparam int TOTAL_W  = 5;

  typedef enum logic [ACTION_W-1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_POP_FRONT  = 2'd1,
    OP_PUSH_BACK  = 2'd2,
    OP_POP_BACK   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE       = 2'd0,
    ST_POP_EMPTY  = 2'd1,
    ST_PUSH_FULL  = 2'd2
  } status_t;

  // Broadcast control from the top level to every cell
  typedef struct packed {
    logic en;
    op_t  op;
  } deq_ctrl_t;

endpackage

// ----- src/deq_cell.sv -----
// One storage cell of the queue row: a word, its occupancy bit and the shift rules.
module deq_cell
  import deq_pkg::*;
#(
  parameter int WIDTH = WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  deq_ctrl_t        ctrl,
  input  logic [WIDTH-1:0] push_word,
  input  logic [WIDTH-1:0] left_data,
  input  logic             left_valid,
  input  logic [WIDTH-1:0] right_data,
  input  logic             right_valid,
  output logic [WIDTH-1:0] data_r,
  output logic             valid_r,
  output logic [WIDTH-1:0] data_nxt,
  output logic             valid_nxt
);

  // Work out the next contents from the neighbours and the operation
  always_comb begin
    data_nxt  = data_r;
    valid_nxt = valid_r;
    if (ctrl.en) begin
      case (ctrl.op)
        OP_PUSH_FRONT: begin
          data_nxt  = left_data;
          valid_nxt = left_valid;
        end
        OP_POP_FRONT: begin
          data_nxt  = right_data;
          valid_nxt = right_valid;
        end
        OP_PUSH_BACK: begin
          // first free cell takes the word
          if (!valid_r && left_valid) begin
            data_nxt  = push_word;
            valid_nxt = 1'b1;
          end
        end
        OP_POP_BACK: begin
          // last occupied cell drops out
          if (valid_r && !right_valid) begin
            valid_nxt = 1'b0;
          end
        end
        default: begin
          data_nxt  = data_r;
          valid_nxt = valid_r;
        end
      endcase
    end
  end

  // Hold occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Hold the word
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

// ----- src/double_ended_queue_top.sv -----
// Top level of the double-ended queue: cell row, count, status and result register.
//
//  Channel | Ports          | Payload (lowest bit up)
//  --------+----------------+------------------------------------------------------
//  in      | in_t*          | tdata: push_value[31:0]; tuser: action[1:0]
//  out     | out_t*         | tdata: front_value, back_value, item_total, is_empty, pad;
//          |                | tuser: status[1:0]
//
//  One word per cycle while results are taken: the cell row updates at the accepting
//  edge and the result is registered at that same edge, offered in the following cycle.
//  The new word is taken whenever the result register is empty or being drained.
//  Reset empties every cell and clears the count; cell words need no reset.
//  A stalled result holds in its register and blocks further input until taken.
module double_ended_queue_top
  import deq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int WIDTH = WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // push_value[31:0]
  input  logic [1:0]  in_tuser,   // action[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // front_value[31:0], back_value[63:32],
                                  // item_total[68:64], is_empty[69], zero pad [71:70]
  output logic [1:0]  out_tuser   // status[1:0]
);

  localparam int CW = $clog2(DEPTH + 1);

  logic             in_fire;
  op_t              op;
  logic [WIDTH-1:0] push_word;
  logic             is_pop;
  status_t          status;
  deq_ctrl_t        ctrl;

  logic [CW-1:0]    count_r;
  logic [CW-1:0]    count_nxt;

  logic [WIDTH-1:0] cell_data_r   [DEPTH];
  logic             cell_valid_r  [DEPTH];
  logic [WIDTH-1:0] cell_data_nxt [DEPTH];
  logic             cell_valid_nxt[DEPTH];

  logic [WIDTH-1:0] back_word;

  logic             out_valid_r;
  status_t          status_r;
  logic [WORD_W-1:0] front_r;
  logic [WORD_W-1:0] back_r;
  logic [TOTAL_W-1:0] total_r;
  logic             empty_r;

  // Handshake and decode
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign op        = op_t'(in_tuser);
  assign push_word = WIDTH'(in_tdata[WORD_W-1:0]);
  assign is_pop    = (op == OP_POP_FRONT) || (op == OP_POP_BACK);

  // Refuse pops on empty and pushes on full
  always_comb begin
    if (is_pop && count_r == '0) begin
      status = ST_POP_EMPTY;
    end else if (!is_pop && count_r == CW'(DEPTH)) begin
      status = ST_PUSH_FULL;
    end else begin
      status = ST_DONE;
    end
  end

  assign ctrl.en = in_fire && (status == ST_DONE);
  assign ctrl.op = op;

  // Advance the count
  always_comb begin
    count_nxt = count_r;
    if (ctrl.en) begin
      if (is_pop) begin
        count_nxt = count_r - CW'(1);
      end else begin
        count_nxt = count_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Row of cells, front at cell 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WIDTH-1:0] l_data;
    logic             l_valid;
    logic [WIDTH-1:0] r_data;
    logic             r_valid;

    if (i == 0) begin : g_first
      assign l_data  = push_word;
      assign l_valid = 1'b1;
    end else begin : g_mid_l
      assign l_data  = cell_data_r[i-1];
      assign l_valid = cell_valid_r[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign r_data  = '0;
      assign r_valid = 1'b0;
    end else begin : g_mid_r
      assign r_data  = cell_data_r[i+1];
      assign r_valid = cell_valid_r[i+1];
    end

    deq_cell #(
      .WIDTH (WIDTH)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .push_word   (push_word),
      .left_data   (l_data),
      .left_valid  (l_valid),
      .right_data  (r_data),
      .right_valid (r_valid),
      .data_r      (cell_data_r[i]),
      .valid_r     (cell_valid_r[i]),
      .data_nxt    (cell_data_nxt[i]),
      .valid_nxt   (cell_valid_nxt[i])
    );
  end

  // Pick the back word: the last occupied cell after the update
  always_comb begin
    back_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (cell_valid_nxt[i] && (i == DEPTH - 1 || !cell_valid_nxt[(i + 1) % DEPTH])) begin
        back_word = back_word | cell_data_nxt[i];
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_fire || (out_valid_r && !out_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      status_r <= status;
      total_r  <= TOTAL_W'(count_nxt);
      empty_r  <= (count_nxt == '0);
      if (count_nxt == '0) begin
        front_r <= '0;
        back_r  <= '0;
      end else begin
        front_r <= WORD_W'(cell_data_nxt[0]);
        back_r  <= WORD_W'(back_word);
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {2'b00, empty_r, total_r, back_r, front_r};

endmodule
